/* design/mfap_pkg.sv */
// Package with the shared types and constants of the max flow block.
`default_nettype none
package mfap_pkg;
  localparam int unsigned MaxNodes = 64;
  localparam int unsigned NodeW = 6;
  localparam int unsigned CapW = 16;
  localparam int unsigned FlowW = 32;
  localparam logic [FlowW-1:0] FlowMax = '1;
  localparam logic [1:0] CfgNodeCount = 2'd0;
  localparam logic [1:0] CfgSource = 2'd1;
  localparam logic [1:0] CfgSink = 2'd2;

  typedef struct packed {
    logic load;
    logic clr;
    logic last;
  } mfap_cmd_t;

  typedef struct packed {
    logic done;
    logic clr_done;
  } mfap_sts_t;
endpackage
`default_nettype wire

/* design/max_flow_augmenting_paths.sv */
// Top level of the max flow block: configuration registers, controller and datapath.
`default_nettype none
// Edges load one per cycle while busy is low, back to back when start stays high. After reset
// and after each result the residual memory (64 x 64 entries) is cleared with busy high. After
// the last edge the block runs breadth-first searches: each search scans the residual row of
// each dequeued node one entry at a time, and each augmenting path is walked once for its
// bottleneck and once to update the residual entries of its edges. The block then pulses
// out_valid for one cycle with out_total_flow; the receiver cannot stall it.
module max_flow_augmenting_paths import mfap_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic busy,
  input  wire logic [NodeW-1:0] in_from_node,
  input  wire logic [NodeW-1:0] in_to_node,
  input  wire logic [CapW-1:0] in_capacity,
  input  wire logic in_last_edge,
  output logic out_valid,
  output logic [FlowW-1:0] out_total_flow,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [6:0] cfg_data
);
  logic [6:0] node_count_r;
  logic [NodeW-1:0] source_r, sink_r;
  mfap_cmd_t cmd;
  mfap_sts_t sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= 7'd64;
      source_r <= '0;
      sink_r <= 6'd63;
    end else if (cfg_valid) begin
      case (cfg_index)
        CfgNodeCount: node_count_r <= cfg_data;
        CfgSource: source_r <= cfg_data[NodeW-1:0];
        CfgSink: sink_r <= cfg_data[NodeW-1:0];
        default: ;
      endcase
    end
  end

  mfap_ctrl u_ctrl (
    .clk, .rst_n, .start, .in_last_edge, .sts, .busy, .cmd
  );

  mfap_dp u_dp (
    .clk, .rst_n, .cmd, .in_from_node, .in_to_node, .in_capacity,
    .node_count(node_count_r), .source_node(source_r), .sink_node(sink_r),
    .sts, .out_valid, .out_total_flow
  );
endmodule
`default_nettype wire

/* design/mfap_ctrl.sv */
// Controller that sequences edge loading, the flow computation and the store clear.
`default_nettype none
module mfap_ctrl import mfap_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire logic in_last_edge,
  input  wire mfap_sts_t sts,
  output logic busy,
  output mfap_cmd_t cmd
);
  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_LOAD  = 3'b010,
    S_RUN   = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_done) state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (start) begin
          cmd.load = 1'b1;
          cmd.last = in_last_edge;
          if (in_last_edge) state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (sts.done) state_nxt = S_CLEAR;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  assign busy = (state_r != S_LOAD);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else state_r <= state_nxt;
  end

  a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> state_r == S_LOAD) else $error("load outside load state");
  a_last_runs: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load && cmd.last |=> state_r == S_RUN) else $error("last edge did not start run");
  a_clear_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RUN && sts.done |=> state_r == S_CLEAR) else $error("no clear after run");
endmodule
`default_nettype wire

/* design/mfap_dp.sv */
// Datapath: residual memory, search queue, path walk and flow accumulation.
`default_nettype none
module mfap_dp import mfap_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire mfap_cmd_t cmd,
  input  wire logic [NodeW-1:0] in_from_node,
  input  wire logic [NodeW-1:0] in_to_node,
  input  wire logic [CapW-1:0] in_capacity,
  input  wire logic [6:0] node_count,
  input  wire logic [NodeW-1:0] source_node,
  input  wire logic [NodeW-1:0] sink_node,
  output mfap_sts_t sts,
  output logic out_valid,
  output logic [FlowW-1:0] out_total_flow
);
  localparam int unsigned NW = (MaxNodes > 1) ? $clog2(MaxNodes) : 1;
  localparam int unsigned AW = 2 * NW;
  localparam int unsigned CW = NW + 1;
  localparam int unsigned DEPTH = MaxNodes * MaxNodes;

  typedef enum logic [12:0] {
    D_IDLE   = 13'b0000000000001,
    D_BINIT  = 13'b0000000000010,
    D_POP    = 13'b0000000000100,
    D_SCANRD = 13'b0000000001000,
    D_SCAN   = 13'b0000000010000,
    D_WRD    = 13'b0000000100000,
    D_WCHK   = 13'b0000001000000,
    D_ARD    = 13'b0000010000000,
    D_AFWD   = 13'b0000100000000,
    D_ARDB   = 13'b0001000000000,
    D_ABWD   = 13'b0010000000000,
    D_DONE   = 13'b0100000000000,
    D_LDWB   = 13'b1000000000000
  } dstate_t;

  logic [FlowW-1:0] mem [DEPTH];
  logic [NW-1:0] queue_mem [MaxNodes];
  logic [NW-1:0] parent_mem [MaxNodes];
  logic [MaxNodes-1:0] vis_r, vis_nxt;

  dstate_t st_r, st_nxt;
  logic [AW-1:0] raddr, waddr;
  logic we;
  logic [FlowW-1:0] wdata, rdata_r;
  logic fwd_r;
  logic [FlowW-1:0] fwd_data_r, ld_base;
  logic [CW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [NW-1:0] u_r, u_nxt, v_r, v_nxt, w_r, w_nxt, p_r, p_nxt;
  logic [CW-1:0] n_eff;
  logic [FlowW-1:0] bott_r, bott_nxt, flow_r, flow_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic clr_done_r, clr_done_nxt;
  logic out_valid_nxt;
  logic qwe, pwe;
  logic [NW-1:0] qwaddr, qwdata, pwaddr, pwdata, qraddr, praddr;
  logic [NW-1:0] qrdata_r, prdata_r;
  logic [AW-1:0] ld_addr_r;
  logic [CapW-1:0] ld_cap_r;
  logic ld_ok_r, ld_last_r;
  logic [FlowW:0] ssum;

  always_comb begin
    if (node_count < 7'd2) n_eff = CW'(2);
    else if ({25'd0, node_count} > 32'(MaxNodes)) n_eff = CW'(MaxNodes);
    else n_eff = CW'(node_count);
  end

  function automatic logic [FlowW-1:0] sat_add(input logic [FlowW-1:0] a,
                                               input logic [FlowW-1:0] b);
    logic [FlowW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[FlowW] ? FlowMax : s[FlowW-1:0];
  endfunction

  // Through ld_base, a read of the entry written at the same edge returns the new value.
  assign ld_base = fwd_r ? fwd_data_r : rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
    fwd_r <= we && (waddr == raddr);
    fwd_data_r <= wdata;
    if (qwe) queue_mem[qwaddr] <= qwdata;
    qrdata_r <= queue_mem[qraddr];
    if (pwe) parent_mem[pwaddr] <= pwdata;
    prdata_r <= parent_mem[praddr];
  end

  always_comb begin
    st_nxt = st_r;
    vis_nxt = vis_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    u_nxt = u_r;
    v_nxt = v_r;
    w_nxt = w_r;
    p_nxt = p_r;
    bott_nxt = bott_r;
    flow_nxt = flow_r;
    clr_nxt = clr_r;
    clr_done_nxt = 1'b0;
    out_valid_nxt = 1'b0;
    we = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = {u_r, v_r};
    qwe = 1'b0;
    qwaddr = tail_r[NW-1:0];
    qwdata = '0;
    pwe = 1'b0;
    pwaddr = '0;
    pwdata = '0;
    qraddr = head_r[NW-1:0];
    praddr = w_r;
    ssum = '0;
    if (cmd.clr) begin
      we = 1'b1;
      waddr = clr_r;
      clr_nxt = clr_r + AW'(1);
      if (clr_r == AW'(DEPTH - 1)) clr_done_nxt = 1'b1;
    end
    case (st_r)
      D_IDLE: begin
        if (cmd.load) begin
          raddr = {in_from_node[NW-1:0], in_to_node[NW-1:0]};
          st_nxt = D_LDWB;
        end
      end
      D_LDWB: begin
        ssum = {1'b0, ld_base} + {17'd0, ld_cap_r};
        if (ld_ok_r) begin
          we = 1'b1;
          waddr = ld_addr_r;
          wdata = ssum[FlowW] ? FlowMax : ssum[FlowW-1:0];
        end
        if (ld_last_r) begin
          flow_nxt = '0;
          if (source_node == sink_node || {1'b0, source_node} >= 7'(n_eff))
            st_nxt = D_DONE;
          else if ({1'b0, sink_node} >= 7'(n_eff)) st_nxt = D_DONE;
          else st_nxt = D_BINIT;
        end else if (cmd.load) begin
          raddr = {in_from_node[NW-1:0], in_to_node[NW-1:0]};
          st_nxt = D_LDWB;
        end else st_nxt = D_IDLE;
      end
      D_BINIT: begin
        vis_nxt = '0;
        vis_nxt[source_node[NW-1:0]] = 1'b1;
        qwe = 1'b1;
        qwaddr = '0;
        qwdata = source_node[NW-1:0];
        head_nxt = '0;
        tail_nxt = CW'(1);
        st_nxt = D_POP;
      end
      D_POP: begin
        if (head_r == tail_r) st_nxt = D_DONE;
        else begin
          head_nxt = head_r + CW'(1);
          st_nxt = D_SCANRD;
        end
      end
      D_SCANRD: begin
        u_nxt = qrdata_r;
        v_nxt = '0;
        st_nxt = D_SCAN;
      end
      D_SCAN: begin
        raddr = {u_r, v_r};
        st_nxt = D_WCHK;
      end
      D_WCHK: begin
        st_nxt = D_SCAN;
        if (!vis_r[v_r] && rdata_r != '0) begin
          pwe = 1'b1;
          pwaddr = v_r;
          pwdata = u_r;
          vis_nxt[v_r] = 1'b1;
          if (v_r == sink_node[NW-1:0]) begin
            w_nxt = v_r;
            p_nxt = u_r;
            bott_nxt = FlowMax;
            st_nxt = D_WRD;
          end else if (tail_r < CW'(MaxNodes)) begin
            qwe = 1'b1;
            qwdata = v_r;
            tail_nxt = tail_r + CW'(1);
          end
        end
        if (st_nxt == D_SCAN) begin
          if ({1'b0, v_r} == n_eff - CW'(1)) st_nxt = D_POP;
          else v_nxt = v_r + NW'(1);
        end
      end
      D_WRD: begin
        // Bottleneck walk: p_r is parent of w_r.
        raddr = {p_r, w_r};
        praddr = p_r;
        st_nxt = D_ARD;
      end
      D_ARD: begin
        if (rdata_r < bott_r) bott_nxt = rdata_r;
        if (p_r == source_node[NW-1:0]) begin
          w_nxt = sink_node[NW-1:0];
          praddr = sink_node[NW-1:0];
          st_nxt = D_AFWD;
          head_nxt = '0;
        end else begin
          w_nxt = p_r;
          p_nxt = prdata_r;
          st_nxt = D_WRD;
        end
      end
      D_AFWD: begin
        p_nxt = prdata_r;
        raddr = {prdata_r, w_r};
        st_nxt = D_ARDB;
      end
      D_ARDB: begin
        we = 1'b1;
        waddr = {p_r, w_r};
        wdata = rdata_r - bott_r;
        raddr = {w_r, p_r};
        st_nxt = D_ABWD;
      end
      D_ABWD: begin
        we = 1'b1;
        waddr = {w_r, p_r};
        wdata = sat_add(rdata_r, bott_r);
        praddr = p_r;
        if (p_r == source_node[NW-1:0]) begin
          flow_nxt = sat_add(flow_r, bott_r);
          st_nxt = D_BINIT;
        end else begin
          w_nxt = p_r;
          st_nxt = D_AFWD;
        end
      end
      D_DONE: begin
        out_valid_nxt = 1'b1;
        st_nxt = D_IDLE;
      end
      default: st_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= D_IDLE;
      clr_r <= '0;
      clr_done_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      st_r <= st_nxt;
      clr_r <= clr_nxt;
      clr_done_r <= clr_done_nxt;
      out_valid <= out_valid_nxt;
    end
    vis_r <= vis_nxt;
    head_r <= head_nxt;
    tail_r <= tail_nxt;
    u_r <= u_nxt;
    v_r <= v_nxt;
    w_r <= w_nxt;
    p_r <= p_nxt;
    bott_r <= bott_nxt;
    flow_r <= flow_nxt;
    if (cmd.load) begin
      ld_addr_r <= {in_from_node[NW-1:0], in_to_node[NW-1:0]};
      ld_cap_r <= in_capacity;
      ld_ok_r <= ({1'b0, in_from_node} < 7'(n_eff)) && ({1'b0, in_to_node} < 7'(n_eff));
      ld_last_r <= cmd.last;
    end
  end

  assign out_total_flow = flow_r;
  assign sts.done = out_valid;
  assign sts.clr_done = clr_done_r;

  a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr |-> st_r == D_IDLE) else $error("clear during computation");
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == D_POP |-> head_r <= tail_r) else $error("queue head passed tail");
  a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result repeated");
endmodule
`default_nettype wire

/* sim/max_flow_augmenting_paths_tb.sv */
// Self-checking testbench of the max flow block with its own flow predictor.
`default_nettype none
module max_flow_augmenting_paths_tb import mfap_pkg::*;;

  localparam int unsigned Nodes = MaxNodes;
  localparam int unsigned CycleLimit = 6000000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [NodeW-1:0] in_from_node;
  logic [NodeW-1:0] in_to_node;
  logic [CapW-1:0] in_capacity;
  logic in_last_edge;
  logic out_valid;
  logic [FlowW-1:0] out_total_flow;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [6:0] cfg_data;

  max_flow_augmenting_paths dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_from_node(in_from_node), .in_to_node(in_to_node),
    .in_capacity(in_capacity), .in_last_edge(in_last_edge),
    .out_valid(out_valid), .out_total_flow(out_total_flow),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  logic [6:0] node_count_reg;
  logic [5:0] source_reg;
  logic [5:0] sink_reg;
  logic [FlowW-1:0] residual [0:Nodes-1][0:Nodes-1];
  logic [FlowW-1:0] expected_flows [$];
  int unsigned cycle_count;
  int unsigned error_count;
  int unsigned edge_count;
  int unsigned flow_count;
  int unsigned cfg_count;
  bit no_gaps;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [FlowW-1:0] sat_sum(logic [FlowW-1:0] a, logic [FlowW-1:0] b);
    logic [FlowW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[FlowW] ? FlowMax : s[FlowW-1:0];
  endfunction

  function automatic int nodes_active();
    if (node_count_reg < 7'd2) return 2;
    if (node_count_reg > 7'(Nodes)) return Nodes;
    return int'(node_count_reg);
  endfunction

  function automatic void clear_residual();
    for (int i = 0; i < Nodes; i++)
      for (int j = 0; j < Nodes; j++)
        residual[i][j] = '0;
  endfunction

  function automatic logic [FlowW-1:0] augment_all();
    int n;
    int src;
    int dst;
    int head;
    int tail;
    int u;
    int v;
    bit found;
    bit [Nodes-1:0] seen;
    int parent [Nodes];
    int bfs_queue [Nodes];
    logic [FlowW-1:0] neck;
    logic [FlowW-1:0] total;
    n = nodes_active();
    src = int'(source_reg);
    dst = int'(sink_reg);
    total = '0;
    if (src == dst || src >= n || dst >= n) return total;
    forever begin
      seen = '0;
      head = 0;
      tail = 0;
      found = 1'b0;
      bfs_queue[tail++] = src;
      seen[src] = 1'b1;
      parent[src] = src;
      while (head < tail && !found) begin
        u = bfs_queue[head++];
        for (v = 0; v < n && !found; v++) begin
          if (!seen[v] && residual[u][v] != '0) begin
            parent[v] = u;
            seen[v] = 1'b1;
            if (v == dst) found = 1'b1;
            else if (tail < Nodes) bfs_queue[tail++] = v;
          end
        end
      end
      if (!found) break;
      neck = FlowMax;
      for (v = dst; v != src; v = parent[v])
        if (residual[parent[v]][v] < neck) neck = residual[parent[v]][v];
      for (v = dst; v != src; v = parent[v]) begin
        u = parent[v];
        residual[u][v] = residual[u][v] - neck;
        residual[v][u] = sat_sum(residual[v][u], neck);
      end
      total = sat_sum(total, neck);
    end
    return total;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 200);
  endfunction

  task automatic send_edge(int from_n, int to_n, int cap, bit last);
    int n;
    int gap;
    start <= 1'b1;
    in_from_node <= NodeW'(from_n);
    in_to_node <= NodeW'(to_n);
    in_capacity <= CapW'(cap);
    in_last_edge <= last;
    do @(posedge clk); while (busy);
    n = nodes_active();
    edge_count++;
    if (from_n < n && to_n < n)
      residual[from_n][to_n] = sat_sum(residual[from_n][to_n], FlowW'(cap));
    if (last) begin
      expected_flows.push_back(augment_all());
      clear_residual();
    end
    gap = gap_len();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (expected_flows.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 7'(value);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_count++;
    case (idx)
      CfgNodeCount: node_count_reg = 7'(value);
      CfgSource: source_reg = 6'(value);
      CfgSink: sink_reg = 6'(value);
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_graph_cfg(int n, int src, int dst);
    wait_idle();
    write_cfg(CfgNodeCount, n);
    write_cfg(CfgSource, src);
    write_cfg(CfgSink, dst);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("max_flow_augmenting_paths_tb: errors");
      $finish;
    end
    if (rst_n && out_valid) begin
      if (expected_flows.size() == 0) begin
        $error("total_flow: unexpected result, actual %0d", out_total_flow);
        error_count <= error_count + 1;
      end else begin
        if (out_total_flow !== expected_flows[0]) begin
          $error("total_flow: expected %0d, actual %0d", expected_flows[0], out_total_flow);
          error_count <= error_count + 1;
        end
        flow_count <= flow_count + 1;
        void'(expected_flows.pop_front());
      end
    end
  end

  task automatic test_basic_graphs();
    send_edge(0, 63, 65535, 1'b1);
    set_graph_cfg(4, 0, 3);
    send_edge(0, 1, 5, 1'b0);
    send_edge(0, 1, 2, 1'b0);
    send_edge(1, 3, 3, 1'b0);
    send_edge(0, 2, 4, 1'b0);
    send_edge(2, 2, 40, 1'b0);
    send_edge(1, 2, 2, 1'b0);
    send_edge(2, 3, 9, 1'b1);
    send_edge(0, 3, 0, 1'b1);
    send_edge(0, 3, 7, 1'b0);
    send_edge(0, 5, 100, 1'b1);
    send_edge(0, 3, 1, 1'b0);
    send_edge(63, 3, 1, 1'b1);
  endtask

  task automatic test_corner_cfg();
    set_graph_cfg(6, 4, 4);
    send_edge(4, 5, 10, 1'b0);
    send_edge(5, 4, 10, 1'b1);
    set_graph_cfg(4, 10, 2);
    send_edge(0, 2, 10, 1'b1);
    set_graph_cfg(4, 1, 9);
    send_edge(1, 3, 10, 1'b1);
    set_graph_cfg(0, 0, 1);
    send_edge(0, 1, 77, 1'b0);
    send_edge(0, 2, 77, 1'b1);
    set_graph_cfg(127, 64 + 0, 64 + 63);
    send_edge(0, 40, 65535, 1'b0);
    send_edge(40, 63, 1000, 1'b0);
    send_edge(0, 63, 65535, 1'b1);
    set_graph_cfg(8, 0, 5);
    send_edge(0, 7, 50, 1'b0);
    send_edge(7, 5, 50, 1'b0);
    send_edge(0, 4, 20, 1'b0);
    wait_idle();
    write_cfg(CfgNodeCount, 6);
    send_edge(4, 5, 30, 1'b1);
  endtask

  task automatic test_random_graphs();
    int n;
    int src;
    int dst;
    int edges;
    int r;
    int a;
    int b;
    int cap;
    int sent;
    sent = 0;
    while (sent < 680) begin
      r = $urandom_range(0, 99);
      if (r < 5) n = $urandom_range(20, 64);
      else if (r < 10) n = $urandom_range(0, 127);
      else n = $urandom_range(2, 12);
      src = $urandom_range(0, 99) < 10 ? $urandom_range(0, 127) : $urandom_range(0, n - 1);
      dst = $urandom_range(0, 99) < 10 ? $urandom_range(0, 127) : $urandom_range(0, n - 1);
      set_graph_cfg(n, src, dst);
      if (n < 2) n = 2;
      if (n > Nodes) n = Nodes;
      src = src % Nodes;
      dst = dst % Nodes;
      no_gaps = ($urandom_range(0, 99) < 30);
      edges = $urandom_range(1, 12);
      for (int e = 0; e < edges; e++) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          a = $urandom_range(0, 63);
          b = $urandom_range(0, 63);
        end else begin
          a = (r < 30) ? src : $urandom_range(0, n - 1);
          b = (r >= 30 && r < 50) ? dst : $urandom_range(0, n - 1);
        end
        r = $urandom_range(0, 99);
        if (r < 60) cap = $urandom_range(1, 20);
        else if (r < 70) cap = 0;
        else cap = $urandom_range(0, 65535);
        send_edge(a % Nodes, b % Nodes, cap, e == edges - 1);
        sent++;
      end
      no_gaps = 1'b0;
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_from_node <= '0;
    in_to_node <= '0;
    in_capacity <= '0;
    in_last_edge <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= CfgNodeCount;
    cfg_data <= '0;
    cycle_count = 0;
    error_count = 0;
    edge_count = 0;
    flow_count = 0;
    cfg_count = 0;
    no_gaps = 1'b0;
    node_count_reg = 7'd64;
    source_reg = 6'd0;
    sink_reg = 6'd63;
    clear_residual();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_graphs();
    test_corner_cfg();
    test_random_graphs();
    wait_idle();
    repeat (16) @(posedge clk);
    if (expected_flows.size() != 0) begin
      $error("total_flow: %0d results never arrived", expected_flows.size());
      error_count++;
    end
    $display("Sent %0d edges, checked %0d flow results, made %0d register writes.",
             edge_count, flow_count, cfg_count);
    $display("Covered clamped node counts, dropped edges, equal and out-of-range endpoints.");
    if (error_count == 0) begin
      $display("max_flow_augmenting_paths_tb: clean");
    end else begin
      $display("max_flow_augmenting_paths_tb: errors");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* files.f */
design/mfap_pkg.sv
design/mfap_ctrl.sv
design/mfap_dp.sv
design/max_flow_augmenting_paths.sv
sim/max_flow_augmenting_paths_tb.sv
